/* hw/rtl/lom_pkg.sv */
// ----------------------------------------------------------------------------
// lom_pkg
// Shared types for the limit order matcher: channel payloads, slot entry and
// controller states.
// ----------------------------------------------------------------------------
package lom_pkg;

  localparam int PRICE_W = 24;
  localparam int QTY_W   = 20;
  localparam int SYM_W   = 8;
  localparam int STAMP_W = 32;

  typedef struct packed {
    logic               is_sell;
    logic [SYM_W-1:0]   symbol_id;
    logic [PRICE_W-1:0] limit_price;
    logic [QTY_W-1:0]   order_qty;
  } order_t;

  typedef struct packed {
    logic               item_kind;
    logic [PRICE_W-1:0] fill_price;
    logic [QTY_W-1:0]   fill_qty;
    logic [QTY_W-1:0]   rested_qty;
    logic               book_full;
    logic [PRICE_W-1:0] last_price;
    logic               last_item;
  } result_t;

  // One resting order as held in the slot memory.
  typedef struct packed {
    logic               side;
    logic [SYM_W-1:0]   symbol;
    logic [PRICE_W-1:0] price;
    logic [QTY_W-1:0]   qty;
    logic [STAMP_W-1:0] stamp;
  } slot_t;

  localparam logic KIND_TRADE   = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_TRADE,
    ST_REST
  } state_t;

endpackage

/* hw/rtl/lom_if.sv */
// ----------------------------------------------------------------------------
// lom_if
// Valid/ready channels for orders and result items.
// ----------------------------------------------------------------------------
interface lom_order_if;
  import lom_pkg::*;
  logic   valid;
  logic   ready;
  order_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface lom_result_if;
  import lom_pkg::*;
  logic    valid;
  logic    ready;
  result_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* hw/rtl/limit_order_matcher.sv */
// ----------------------------------------------------------------------------
// limit_order_matcher
// Matches one limit order against the resting orders of the opposite side,
// emits one trade per fill and a closing summary, then rests the remainder.
// ----------------------------------------------------------------------------
//
//  channel | dir | payload   | transfer
//  --------+-----+-----------+-------------------------------------------
//  ord     | in  | order_t   | one limit order, when ord.valid & ord.ready
//  res     | out | result_t  | one trade or summary, res.valid & res.ready
//
// Each match pass sweeps the slot memory once, one read per slot through the
// single read port with registered read data, then makes the fill. After the
// last fill, or after a sweep that finds nothing, comes the summary; the sweep
// through the single read port sets how long an order is in work.
// Reset clears the slot valid bits, the arrival counter and the controller;
// the memory contents are not cleared and are read only behind a valid bit.
// A stalled result holds the controller at the next fill or at the summary;
// the next order is taken as soon as the summary sits in the output register.
module limit_order_matcher
  import lom_pkg::*;
#(
  parameter int ORDER_SLOTS  = 32,
  parameter int SYMBOL_COUNT = 256
) (
  input  logic         clk,
  input  logic         rst,
  lom_order_if.sink    ord,
  lom_result_if.source res
);

  localparam int IW = $clog2(ORDER_SLOTS);
  localparam int CW = $clog2(ORDER_SLOTS + 1);
  localparam logic [CW-1:0] SLOTS_C = CW'(ORDER_SLOTS);

  // Symbol reduction table, folded at elaboration.
  logic [SYM_W-1:0] sym_tab [256];
  for (genvar g = 0; g < 256; g++) begin : g_sym
    localparam int SYM_MOD = g % SYMBOL_COUNT;
    assign sym_tab[g] = SYM_W'(SYM_MOD);
  end

  state_t state, state_next;

  // Order being worked on.
  logic               o_sell;
  logic [SYM_W-1:0]   o_sym;
  logic [PRICE_W-1:0] o_price;
  logic [QTY_W-1:0]   o_qty;
  logic [PRICE_W-1:0] o_last;
  logic [CW-1:0]      fill_cnt;
  logic [STAMP_W-1:0] arrival;

  // Sweep state.
  logic [CW-1:0]      scan_cnt;
  logic               rd_vld;
  logic [IW-1:0]      rd_idx;
  logic               best_found;
  logic [IW-1:0]      best_idx;
  slot_t              best;
  logic [STAMP_W-1:0] best_age;
  logic               free_found;
  logic [IW-1:0]      free_idx;

  logic [ORDER_SLOTS-1:0] slot_valid;

  // Memory port.
  logic          ram_we;
  logic [IW-1:0] ram_waddr;
  slot_t         ram_wdata;
  logic [IW-1:0] ram_raddr;
  slot_t         ram_rdata;

  lom_ram #(
    .WIDTH ($bits(slot_t)),
    .DEPTH (ORDER_SLOTS)
  ) u_slots (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  logic accept, out_free, scan_done;
  assign accept    = ord.valid && ord.ready;
  assign out_free  = !res.valid || res.ready;
  assign scan_done = (scan_cnt == SLOTS_C) && !rd_vld;

  // Candidate test on the entry coming out of memory.
  logic               cand, better;
  logic [STAMP_W-1:0] cand_age;
  always_comb begin
    cand_age = arrival - ram_rdata.stamp;
    cand = slot_valid[rd_idx] && (ram_rdata.side != o_sell) &&
           (ram_rdata.symbol == o_sym) &&
           (o_sell ? !(o_price > ram_rdata.price) : !(o_price < ram_rdata.price));
    if (!best_found) begin
      better = 1'b1;
    end else if (ram_rdata.price != best.price) begin
      better = o_sell ? (ram_rdata.price > best.price) : (ram_rdata.price < best.price);
    end else begin
      better = cand_age > best_age;
    end
  end

  // Fill arithmetic.
  logic [QTY_W-1:0]   tq, rest_left, ord_left;
  logic [PRICE_W-1:0] tp;
  assign tq        = (o_qty < best.qty) ? o_qty : best.qty;
  assign tp        = o_sell ? o_price : best.price;
  assign rest_left = best.qty - tq;
  assign ord_left  = o_qty - tq;

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) state_next = ST_SCAN;
      end
      ST_SCAN: begin
        if (scan_done) begin
          state_next = (best_found && o_qty != '0) ? ST_TRADE : ST_REST;
        end
      end
      ST_TRADE: begin
        if (out_free) begin
          if (rest_left != '0 || ord_left == '0 || fill_cnt + CW'(1) == SLOTS_C) begin
            state_next = ST_REST;
          end else begin
            state_next = ST_SCAN;
          end
        end
      end
      ST_REST: begin
        if (out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Outputs of the controller.
  always_comb begin
    ord.ready = (state == ST_IDLE);
    ram_raddr = scan_cnt[IW-1:0];
    ram_we    = 1'b0;
    ram_waddr = best_idx;
    ram_wdata = best;
    case (state)
      ST_TRADE: begin
        ram_we        = out_free;
        ram_wdata.qty = rest_left;
      end
      ST_REST: begin
        ram_we    = out_free && (o_qty != '0) && free_found;
        ram_waddr = free_idx;
        ram_wdata = '{side: o_sell, symbol: o_sym, price: o_price, qty: o_qty,
                      stamp: arrival};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      slot_valid <= '0;
      arrival    <= '0;
      res.valid  <= 1'b0;
      rd_vld     <= 1'b0;
      scan_cnt   <= '0;
      best_found <= 1'b0;
      free_found <= 1'b0;
      fill_cnt   <= '0;
    end else begin
      state <= state_next;
      // Load a trade or summary into the output register; drop it once taken.
      if ((state inside {ST_TRADE, ST_REST}) && out_free) begin
        res.valid <= 1'b1;
      end else if (res.ready) begin
        res.valid <= 1'b0;
      end

      case (state)
        ST_IDLE: begin
          if (accept) begin
            o_sell     <= ord.data.is_sell;
            o_sym      <= sym_tab[ord.data.symbol_id];
            o_price    <= ord.data.limit_price;
            o_qty      <= ord.data.order_qty;
            o_last     <= ord.data.limit_price;
            fill_cnt   <= '0;
            free_found <= 1'b0;
            scan_cnt   <= '0;
            rd_vld     <= 1'b0;
            best_found <= 1'b0;
          end
        end
        ST_SCAN: begin
          // Advance the read address; evaluate the entry read last cycle.
          if (scan_cnt != SLOTS_C) begin
            rd_vld   <= 1'b1;
            rd_idx   <= scan_cnt[IW-1:0];
            scan_cnt <= scan_cnt + CW'(1);
          end else begin
            rd_vld <= 1'b0;
          end
          if (rd_vld) begin
            if (cand && better) begin
              best_found <= 1'b1;
              best_idx   <= rd_idx;
              best       <= ram_rdata;
              best_age   <= cand_age;
            end
            if (!slot_valid[rd_idx] && !free_found) begin
              free_found <= 1'b1;
              free_idx   <= rd_idx;
            end
          end
        end
        ST_TRADE: begin
          if (out_free) begin
            res.data  <= '{item_kind: KIND_TRADE, fill_price: tp, fill_qty: tq,
                           rested_qty: '0, book_full: 1'b0, last_price: '0,
                           last_item: 1'b0};
            o_last    <= tp;
            o_qty     <= ord_left;
            fill_cnt  <= fill_cnt + CW'(1);
            if (rest_left == '0) begin
              // Drop the emptied slot; it may now be the lowest free one.
              slot_valid[best_idx] <= 1'b0;
              if (!free_found || best_idx < free_idx) begin
                free_found <= 1'b1;
                free_idx   <= best_idx;
              end
            end
            scan_cnt   <= '0;
            rd_vld     <= 1'b0;
            best_found <= 1'b0;
          end
        end
        ST_REST: begin
          if (out_free) begin
            res.data  <= '{item_kind: KIND_SUMMARY, fill_price: '0, fill_qty: '0,
                           rested_qty: (o_qty != '0 && free_found) ? o_qty : '0,
                           book_full: (o_qty != '0) && !free_found,
                           last_price: o_last, last_item: 1'b1};
            if (o_qty != '0 && free_found) slot_valid[free_idx] <= 1'b1;
            arrival <= arrival + STAMP_W'(1);
          end
        end
        default: ;
      endcase
    end
  end

  // A new order is only taken with the controller idle.
  a_one_order: assert property (@(posedge clk) disable iff (rst)
    accept |=> !ord.ready)
    else $error("order taken while another is in work");

  // Fills per order never exceed the slot count.
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill_cnt <= SLOTS_C)
    else $error("fill count out of range");

  // A summary item carries no fill.
  a_summary_clean: assert property (@(posedge clk) disable iff (rst)
    (res.valid && res.data.last_item) |->
      (res.data.fill_qty == '0 && res.data.item_kind == KIND_SUMMARY))
    else $error("summary item malformed");

  // The arrival counter moves only when a summary is issued.
  a_arrival_step: assert property (@(posedge clk) disable iff (rst)
    (state != ST_REST) |=> $stable(arrival))
    else $error("arrival counter moved outside summary");

endmodule

/* hw/rtl/lom_ram.sv */
// ----------------------------------------------------------------------------
// lom_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module lom_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
